@@ src/assert_macros.svh @@
// assertion helpers shared by the dhcp option extractor modules
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/dhcpox_pkg.sv @@
// shared types, codes and constants of the dhcp option extractor
// no dependencies
package dhcpox_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_VALUE     = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_BADCOOKIE = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_OVERSIZE  = 3'd5
  } status_t;

  // register index, taken from paddr[2]
  localparam logic REG_WANTED_CODE   = 1'b0;
  localparam logic REG_MAX_VALUE_LEN = 1'b1;

  localparam logic [7:0] WANTED_CODE_RST   = 8'd53;
  localparam logic [7:0] MAX_VALUE_LEN_RST = 8'd255;
  localparam logic [7:0] END_CODE          = 8'd255;

  typedef struct packed {
    logic [7:0] wanted_code;
    logic [7:0] max_value_len;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] value_byte;
    logic       value_valid;
    logic [7:0] value_index;
    logic [7:0] found_length;
    logic       final_res;
  } res_t;

  // magic cookie byte at a given position
  function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'd99;
      2'd1:    val = 8'd130;
      2'd2:    val = 8'd83;
      default: val = 8'd99;
    endcase
    return val;
  endfunction

endpackage

@@ src/dhcpox_cfg_regs.sv @@
// apb-style configuration registers of the dhcp option extractor
// depends on dhcpox_pkg
module dhcpox_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dhcpox_pkg::cfg_t   cfg_o
);
  import dhcpox_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_r;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wanted_code   <= WANTED_CODE_RST;
      cfg_r.max_value_len <= MAX_VALUE_LEN_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_WANTED_CODE:   cfg_r.wanted_code   <= pwdata[7:0];
        REG_MAX_VALUE_LEN: cfg_r.max_value_len <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (paddr[2])
      REG_WANTED_CODE:   prdata = {24'd0, cfg_r.wanted_code};
      REG_MAX_VALUE_LEN: prdata = {24'd0, cfg_r.max_value_len};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ src/dhcpox_parser.sv @@
// per-byte option walker: state registers plus one step of next-state logic
// depends on dhcpox_pkg and assert_macros.svh
module dhcpox_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  dhcpox_pkg::cfg_t   cfg_i,
  output logic               res_valid_o,
  output dhcpox_pkg::res_t   res_o
);
  import dhcpox_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] cookie_pos_r, cookie_pos_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       is_match_r, is_match_nxt;
  logic [7:0] opt_length_r, opt_length_nxt;
  logic [7:0] value_pos_r, value_pos_nxt;
  logic       conc;
  logic [7:0] left_dec;

  assign left_dec = bytes_left_r - 8'd1;

  // one parsing step for the beat on the input
  always_comb begin
    phase_nxt      = phase_r;
    cookie_pos_nxt = cookie_pos_r;
    bytes_left_nxt = bytes_left_r;
    is_match_nxt   = is_match_r;
    opt_length_nxt = opt_length_r;
    value_pos_nxt  = value_pos_r;
    conc           = 1'b0;
    res_valid_o    = 1'b0;
    res_o          = '0;
    res_o.status   = ST_VALUE;
    unique case (phase_r)
      PH_COOKIE: begin
        if (byte_i != cookie_byte(cookie_pos_r)) begin
          conc = 1'b1;
          res_o.status = ST_BADCOOKIE;
        end else if (cookie_pos_r == 2'd3) begin
          if (last_i) begin
            conc = 1'b1;
            res_o.status = ST_NOTFOUND;
          end else begin
            phase_nxt = PH_CODE;
          end
        end else if (last_i) begin
          conc = 1'b1;
          res_o.status = ST_BADCOOKIE;
        end else begin
          cookie_pos_nxt = cookie_pos_r + 2'd1;
        end
      end
      PH_CODE: begin
        if (byte_i == END_CODE) begin
          conc = 1'b1;
          res_o.status = ST_NOTFOUND;
        end else if (last_i) begin
          conc = 1'b1;
          res_o.status = ST_OVERRUN;
        end else begin
          is_match_nxt = (byte_i == cfg_i.wanted_code);
          phase_nxt    = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_length_nxt = byte_i;
        bytes_left_nxt = byte_i;
        value_pos_nxt  = 8'd0;
        if (byte_i == 8'd0) begin
          if (is_match_r) begin
            conc = 1'b1;
            res_o.status = ST_FOUND;
          end else if (last_i) begin
            conc = 1'b1;
            res_o.status = ST_NOTFOUND;
          end else begin
            phase_nxt = PH_CODE;
          end
        end else if (last_i) begin
          conc = 1'b1;
          res_o.status = ST_OVERRUN;
        end else begin
          phase_nxt = (is_match_r && (byte_i > cfg_i.max_value_len)) ? PH_SKIP : PH_VALUE;
        end
      end
      PH_VALUE: begin
        bytes_left_nxt = left_dec;
        value_pos_nxt  = value_pos_r + 8'd1;
        if (left_dec == 8'd0) begin
          if (is_match_r) begin
            conc = 1'b1;
            res_o.status       = ST_FOUND;
            res_o.value_byte   = byte_i;
            res_o.value_valid  = 1'b1;
            res_o.value_index  = value_pos_r;
            res_o.found_length = opt_length_r;
          end else if (last_i) begin
            conc = 1'b1;
            res_o.status = ST_NOTFOUND;
          end else begin
            phase_nxt = PH_CODE;
          end
        end else if (last_i) begin
          conc = 1'b1;
          res_o.status = ST_OVERRUN;
        end else if (is_match_r) begin
          res_valid_o       = 1'b1;
          res_o.status      = ST_VALUE;
          res_o.value_byte  = byte_i;
          res_o.value_valid = 1'b1;
          res_o.value_index = value_pos_r;
        end
      end
      PH_SKIP: begin
        bytes_left_nxt = left_dec;
        if (left_dec == 8'd0) begin
          conc = 1'b1;
          res_o.status = ST_OVERSIZE;
        end else if (last_i) begin
          conc = 1'b1;
          res_o.status = ST_OVERRUN;
        end
      end
      PH_DONE: begin
        if (last_i) phase_nxt = PH_COOKIE;
      end
      default: begin
        phase_nxt = PH_COOKIE;
      end
    endcase

    // concluding result: wait for packet end, or rearm on it
    if (conc) begin
      res_valid_o     = 1'b1;
      res_o.final_res = 1'b1;
      phase_nxt       = PH_DONE;
    end
    if ((conc || phase_r == PH_DONE) && last_i) begin
      phase_nxt      = PH_COOKIE;
      cookie_pos_nxt = 2'd0;
      bytes_left_nxt = 8'd0;
      is_match_nxt   = 1'b0;
      opt_length_nxt = 8'd0;
      value_pos_nxt  = 8'd0;
    end
  end

  // state registers, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COOKIE;
      cookie_pos_r <= 2'd0;
      bytes_left_r <= 8'd0;
      is_match_r   <= 1'b0;
      opt_length_r <= 8'd0;
      value_pos_r  <= 8'd0;
    end else if (acc_i) begin
      phase_r      <= phase_nxt;
      cookie_pos_r <= cookie_pos_nxt;
      bytes_left_r <= bytes_left_nxt;
      is_match_r   <= is_match_nxt;
      opt_length_r <= opt_length_nxt;
      value_pos_r  <= value_pos_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_done_silent, (acc_i && phase_r == PH_DONE) |-> !res_valid_o, "result while waiting for packet end")
  `ASSERT_CLK(a_value_not_final, (res_valid_o && res_o.status == ST_VALUE) |-> (res_o.value_valid && !res_o.final_res), "bad value beat")
  `ASSERT_CLK(a_final_parks, (acc_i && res_valid_o && res_o.final_res && !last_i) |=> phase_r == PH_DONE, "final result did not park parser")

endmodule

@@ src/dhcpox_out_fifo.sv @@
// two-entry result queue that decouples the parser from output stalls
// depends on dhcpox_pkg and assert_macros.svh
module dhcpox_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  dhcpox_pkg::res_t   push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dhcpox_pkg::res_t   out_data_o
);
  import dhcpox_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign space_o     = (count_r != 2'd2);
  assign out_valid_o = (count_r != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop)    rd_ptr_r <= ~rd_ptr_r;
      if (push_i && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push_i) count_r <= count_r - 2'd1;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_range, count_r != 2'd3, "queue count out of range")
  `ASSERT_CLK(a_no_overflow, push_i |-> space_o, "push into full queue")
  `ASSERT_CLK(a_count_inc, (push_i && !pop) |=> count_r == $past(count_r) + 2'd1, "count did not advance")

endmodule

@@ src/dhcp_option_extractor.sv @@
// top level of the dhcp option extractor
// depends on dhcpox_pkg, dhcpox_cfg_regs, dhcpox_parser, dhcpox_out_fifo
//
// Usage:
//   Input stream: one byte of a dhcp options field per beat, cookie first;
//   in_tlast marks the last byte of the packet. Output stream: zero or one
//   result beat per input beat; out_tlast marks the concluding result of a
//   packet. The apb port holds wanted_code (0x0) and max_value_len (0x4);
//   write them only while no packet is in flight.
//   Results enter the result queue as their input beats are accepted.
//   Throughput: one byte per cycle while in_tready is high; the step logic
//   from the parser state registers to the two-entry queue is a single pass.
//   Stall: the queue keeps accepting bytes until both entries hold results,
//   then in_tready drops until the receiver takes one.
//   Reset: synchronous, active low; registers return to wanted_code 53 and
//   max_value_len 255, the queue empties and the parser waits for a cookie.
module dhcp_option_extractor (
  input  logic        clk,
  input  logic        rst_n,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // packet_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [10:3] value_byte, [11] value_valid, [19:12] value_index,
  // [27:20] found_length, [31:28] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast   // final_res
);
  import dhcpox_pkg::*;

  cfg_t cfg;
  res_t res, out_res;
  logic res_valid;
  logic acc;
  logic space;

  assign in_tready = space;
  assign acc       = in_tvalid && in_tready;

  dhcpox_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dhcpox_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (acc),
    .byte_i      (in_tdata),
    .last_i      (in_tlast),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dhcpox_out_fifo u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (acc && res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_res)
  );

  // pack result beat
  assign out_tdata = {4'd0, out_res.found_length, out_res.value_index,
                      out_res.value_valid, out_res.value_byte, out_res.status};
  assign out_tlast = out_res.final_res;

endmodule
